// ===== design/fsif_pkg.sv =====
`default_nettype none

package fsif_pkg;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_UPPER_C = 8'h43;

  // Characters used to build digits.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Index of the most significant digit of each conversion.
  localparam logic [2:0] POS_CHAR = 3'd0;
  localparam logic [2:0] POS_HEX  = 3'd3;
  localparam logic [2:0] POS_DEC  = 3'd4;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_HEX  = 2'd1,
    KIND_DEC  = 2'd2
  } cmd_kind_t;

  // One decoded command: a single character, or a value to convert.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] data;
  } cmd_t;

  // Multiples of the decimal place weights: DEC_STEP[place][digit].
  localparam logic [16:0] DEC_STEP [0:4][0:9] = '{
    '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700, 17'd800,
      17'd900},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000, 17'd7000,
      17'd8000, 17'd9000},
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000, 17'd60000,
      17'd70000, 17'd80000, 17'd90000}
  };

endpackage

`default_nettype wire

// ===== design/fsif_fmt_if.sv =====
`default_nettype none

interface fsif_fmt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [15:0] value;
  logic        fmt_last;

  modport source (output valid, fmt_char, value, fmt_last, input ready);
  modport sink   (input valid, fmt_char, value, fmt_last, output ready);
endinterface

`default_nettype wire

// ===== design/fsif_char_if.sv =====
`default_nettype none

interface fsif_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, out_char, out_last, input ready);
  modport sink   (input valid, out_char, out_last, output ready);
endinterface

`default_nettype wire

// ===== design/fsif_decode.sv =====
`default_nettype none

module fsif_decode
  import fsif_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  fsif_fmt_if.sink   fmt,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_take
);

  logic pending;
  logic pending_next;
  logic emit;
  logic in_fire;
  cmd_t cmd_next;

  assign fmt.ready = !cmd_valid || cmd_take;
  assign in_fire   = fmt.valid && fmt.ready;

  always_comb begin
    emit          = 1'b0;
    pending_next  = pending;
    cmd_next.kind = KIND_CHAR;
    cmd_next.data = {8'h00, fmt.fmt_char};
    if (pending) begin
      pending_next = 1'b0;
      unique case (fmt.fmt_char) inside
        CH_LOWER_X, CH_UPPER_X: begin
          emit          = 1'b1;
          cmd_next.kind = KIND_HEX;
          cmd_next.data = fmt.value;
        end
        CH_LOWER_D, CH_LOWER_I: begin
          emit          = 1'b1;
          cmd_next.kind = KIND_DEC;
          cmd_next.data = fmt.value;
        end
        CH_LOWER_C, CH_UPPER_C: begin
          emit          = 1'b1;
          cmd_next.kind = KIND_CHAR;
          cmd_next.data = {8'h00, fmt.value[7:0]};
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (fmt.fmt_char == CH_PERCENT) begin
      pending_next = 1'b1;
    end else begin
      emit = 1'b1;
    end
    // The end of the string always drops a dangling escape.
    if (fmt.fmt_last) begin
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        cmd_valid <= 1'b0;
      end
      if (in_fire) begin
        pending <= pending_next;
        if (emit) begin
          cmd_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/fsif_serial.sv =====
`default_nettype none

module fsif_serial
  import fsif_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  input  wire logic  cmd_valid,
  output logic       cmd_take,
  fsif_char_if.source chars
);

  logic        busy;
  cmd_kind_t   kind;
  logic [15:0] rem;
  logic [2:0]  pos;

  logic        fire;
  logic        at_last;
  logic        load;
  logic [3:0]  dec_digit;
  logic [15:0] rem_next;
  logic [3:0]  nibble;
  logic [2:0]  pos_init;

  assign at_last  = (pos == POS_CHAR);
  assign fire     = chars.valid && chars.ready;
  assign load     = cmd_valid && (!busy || (fire && at_last));
  assign cmd_take = load;

  // Decimal digit: largest multiple of the place weight not above the remainder.
  always_comb begin
    dec_digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, rem} >= DEC_STEP[pos][k]) begin
        dec_digit = 4'(k);
      end
    end
    rem_next = 16'({1'b0, rem} - DEC_STEP[pos][dec_digit]);
  end

  assign nibble = rem[{pos[1:0], 2'b00} +: 4];

  always_comb begin
    unique case (kind)
      KIND_CHAR: chars.out_char = rem[7:0];
      KIND_HEX: begin
        if (nibble < 4'd10) begin
          chars.out_char = CH_ZERO + {4'h0, nibble};
        end else begin
          chars.out_char = CH_UPPER_A + {4'h0, nibble - 4'd10};
        end
      end
      KIND_DEC: chars.out_char = CH_ZERO + {4'h0, dec_digit};
      default:  chars.out_char = rem[7:0];
    endcase
  end

  assign chars.valid    = busy;
  assign chars.out_last = at_last;

  always_comb begin
    unique case (cmd.kind)
      KIND_CHAR: pos_init = POS_CHAR;
      KIND_HEX:  pos_init = POS_HEX;
      KIND_DEC:  pos_init = POS_DEC;
      default:   pos_init = POS_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (fire && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= cmd.kind;
      rem  <= cmd.data;
      pos  <= pos_init;
    end else if (fire) begin
      pos <= pos - 3'd1;
      if (kind == KIND_DEC) begin
        rem <= rem_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/format_string_int_formatter.sv =====
// Format string formatter for a single 16-bit value.
// The fmt channel takes one format character per word, with the value and a flag
// that marks the last character of the string. The chars channel returns ASCII
// characters one word at a time; out_last marks the last word caused by one input.
// An ordinary character gives one word. A percent sign arms an escape and gives
// nothing; the next character then gives four hex digits (x, X), five decimal
// digits (d, i), the low byte of the value (c, C), or nothing for anything else.
// The first word of an input is offered once the input has passed the command
// buffer in the decoder and then the serializer's busy and remainder registers.
// Throughput: one output word per cycle while chars is ready; an input gives one
// word for a plain character, four for hex and five for decimal. The output
// register and the one-word command buffer set that rate; inputs that give no
// word still take a handshake on fmt. Decimal digits come out one per cycle while
// chars is ready, by compare-and-subtract on the running remainder; no divider.
// Reset clears the armed escape and empties both registers; no word is lost or
// repeated when chars stalls: the current word holds and, once the buffer is
// full, fmt.ready drops until the serializer takes the buffered command.
`default_nettype none

module format_string_int_formatter
  import fsif_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  fsif_fmt_if.sink    fmt,
  fsif_char_if.source chars
);

  // Decoded command handed from the escape decoder to the character serializer.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  fsif_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  fsif_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .chars     (chars)
  );

endmodule

`default_nettype wire
